// ===== sv/sei_pkg.sv =====
// Shared constants for the sorption Euler integrator core.
package sei_pkg;

  // Default widths of the step count, the fixed-point words and their fraction
  localparam int unsigned STEP_COUNT_BITS = 16;
  localparam int unsigned WORD_BITS       = 32;
  localparam int unsigned FRAC_BITS       = 16;

  // Risk level is Q1.16, one is represented by 2^16
  localparam int unsigned RISK_FRAC_BITS = 16;
  localparam int unsigned RISK_BITS      = RISK_FRAC_BITS + 1;
  localparam logic [RISK_BITS-1:0] RISK_ONE  = RISK_BITS'(1) << RISK_FRAC_BITS;
  localparam logic [RISK_BITS-1:0] RISK_HALF = RISK_BITS'(1) << (RISK_FRAC_BITS - 1);

  // Configuration register map
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ADSORPTION_RATE     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DESORPTION_RATE     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MASS_CAPACITY       = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TIME_STEP           = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WATER_CONCENTRATION = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SAFE_BOUND          = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GOLD_BOUND          = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HARD_BOUND          = 3'd7;

endpackage

// ===== sv/sorption_euler_integrator_core.sv =====
// Sorption integrator: forward-Euler mass build-up with a banded risk score.
//
// A request (start_i high while busy_o is low) carries a step count N. The mass
// starts at zero and takes N Euler steps M += dt*(kads*C - kdes*M), clamped to
// [0, capacity] after each step; then the final mass is scored against the
// safe, gold and hard bounds. busy_o stays high for the whole request and the
// result is shown on done_o for a single cycle; it cannot be held off, so the
// receiver must take it then. All products go through one multiplier that
// builds each product from P partial products (P = 1 for WORD_BITS up to 33,
// P = 4 above). A step takes two products, a difference and the clamped
// update, and the risk ramp uses a restoring divider, which is skipped when
// the mass lies at or below safe or at or above hard. Configuration writes
// are always ready and must only be issued while busy_o is low.
module sorption_euler_integrator_core #(
  parameter int unsigned STEP_COUNT_BITS = sei_pkg::STEP_COUNT_BITS,
  parameter int unsigned WORD_BITS       = sei_pkg::WORD_BITS,
  parameter int unsigned FRAC_BITS       = sei_pkg::FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sei_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [WORD_BITS-1:0]                cfg_data_i,
  // request
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [STEP_COUNT_BITS-1:0]          step_count_i,
  // result
  output logic                                done_o,
  output logic [WORD_BITS-2:0]                final_mass_o,
  output logic [sei_pkg::RISK_BITS-1:0]       risk_level_o
);

  // Magnitude width of every operand, digit split of the shared multiplier
  localparam int unsigned W1      = WORD_BITS - 1;
  localparam int unsigned MD      = (W1 > 32) ? 2 : 1;
  localparam int unsigned DW      = (W1 + MD - 1) / MD;
  localparam int unsigned PW      = MD * DW;
  localparam int unsigned NPROD   = MD * MD;
  localparam int unsigned AW      = 2 * PW + FRAC_BITS + 1;
  localparam int unsigned RF      = sei_pkg::RISK_FRAC_BITS;
  localparam int unsigned RB      = sei_pkg::RISK_BITS;
  localparam int unsigned DCW     = $clog2(RF);
  localparam logic [1:0]     PC_LAST  = 2'(NPROD - 1);
  localparam logic [DCW-1:0] DIV_LAST = DCW'(RF - 1);
  localparam logic [W1-1:0]  WMAX     = {W1{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_MEND, S_DIFF, S_UPD, S_RISK, S_DIV
  } state_e;

  typedef enum logic [1:0] {
    OP_GAIN, OP_LOSS, OP_DELTA
  } mul_op_e;

  // configuration registers (rates already clamped at zero)
  logic [W1-1:0] ka_q, kd_q, cap_q, dt_q, conc_q, safe_q, gold_q, hard_q;

  // sequencer and datapath registers
  state_e                 state_q;
  mul_op_e                op_q;
  logic [1:0]             pc_q;
  logic [W1-1:0]          mul_a_q, mul_b_q;
  logic [AW-1:0]          acc_q;
  logic [STEP_COUNT_BITS-1:0] cnt_q;
  logic [W1-1:0]          m_q, gain_q, loss_q, delta_q;
  logic                   up_q;
  logic [W1-1:0]          rem_q, den_q;
  logic [RF-1:0]          quo_q;
  logic [DCW-1:0]         div_cnt_q;
  logic                   upper_q;
  logic                   done_q;
  logic [W1-1:0]          mass_out_q;
  logic [RB-1:0]          risk_out_q;

  // multiplier datapath signals
  logic                   ia, ib;
  logic [PW-1:0]          a_pad, b_pad;
  logic [DW-1:0]          a_dig, b_dig;
  logic [2*DW-1:0]        pp;
  logic [AW-1:0]          pp_sh;
  logic                   mul_ovf, mul_frac_nz;
  logic [W1-1:0]          mul_floor, mul_sat_dn, mul_sat_up;

  // step and scoring signals
  logic [W1:0]            gl_diff, lg_diff, up_sum, dn_diff;
  logic [W1-1:0]          m_next;
  logic [W1:0]            trial, trial_sub;
  logic                   trial_ge;
  logic [RF-1:0]          quo_next;

  assign cfg_ready_o = 1'b1;

  // select digits and place the partial product
  always_comb begin
    ia    = (MD == 2) ? pc_q[0] : 1'b0;
    ib    = (MD == 2) ? pc_q[1] : 1'b0;
    a_pad = PW'(mul_a_q);
    b_pad = PW'(mul_b_q);
    a_dig = ia ? a_pad[PW-1 -: DW] : a_pad[DW-1:0];
    b_dig = ib ? b_pad[PW-1 -: DW] : b_pad[DW-1:0];
    pp    = (2*DW)'(a_dig) * (2*DW)'(b_dig);
    pp_sh = (AW'(pp) << (ia ? DW : 0)) << (ib ? DW : 0);
  end

  // scale the finished product down by the fraction bits and saturate
  always_comb begin
    mul_ovf     = |acc_q[AW-1:W1+FRAC_BITS];
    mul_floor   = acc_q[W1+FRAC_BITS-1:FRAC_BITS];
    mul_frac_nz = |acc_q[FRAC_BITS-1:0];
    mul_sat_dn  = mul_ovf ? WMAX : mul_floor;
    if (mul_ovf || (mul_frac_nz && (mul_floor == WMAX))) begin
      mul_sat_up = WMAX;
    end else if (mul_frac_nz) begin
      mul_sat_up = mul_floor + W1'(1);
    end else begin
      mul_sat_up = mul_floor;
    end
  end

  // drift sign and magnitude, clamped mass update
  always_comb begin
    gl_diff = {1'b0, gain_q} - {1'b0, loss_q};
    lg_diff = {1'b0, loss_q} - {1'b0, gain_q};
    up_sum  = {1'b0, m_q} + {1'b0, delta_q};
    dn_diff = {1'b0, m_q} - {1'b0, delta_q};
    if (up_q) begin
      m_next = (up_sum > {1'b0, cap_q}) ? cap_q : up_sum[W1-1:0];
    end else begin
      m_next = dn_diff[W1] ? '0 : dn_diff[W1-1:0];
    end
  end

  // one restoring division bit
  always_comb begin
    trial     = (div_cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
    trial_ge  = trial >= {1'b0, den_q};
    trial_sub = trial - {1'b0, den_q};
    quo_next  = {quo_q[RF-2:0], trial_ge};
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ka_q   <= '0;
      kd_q   <= '0;
      cap_q  <= '0;
      dt_q   <= '0;
      conc_q <= '0;
      safe_q <= '0;
      gold_q <= '0;
      hard_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        sei_pkg::REG_ADSORPTION_RATE:
          ka_q <= cfg_data_i[WORD_BITS-1] ? '0 : cfg_data_i[W1-1:0];
        sei_pkg::REG_DESORPTION_RATE:
          kd_q <= cfg_data_i[WORD_BITS-1] ? '0 : cfg_data_i[W1-1:0];
        sei_pkg::REG_MASS_CAPACITY:       cap_q  <= cfg_data_i[W1-1:0];
        sei_pkg::REG_TIME_STEP:           dt_q   <= cfg_data_i[W1-1:0];
        sei_pkg::REG_WATER_CONCENTRATION: conc_q <= cfg_data_i[W1-1:0];
        sei_pkg::REG_SAFE_BOUND:          safe_q <= cfg_data_i[W1-1:0];
        sei_pkg::REG_GOLD_BOUND:          gold_q <= cfg_data_i[W1-1:0];
        sei_pkg::REG_HARD_BOUND:          hard_q <= cfg_data_i[W1-1:0];
        default: ;
      endcase
    end
  end

  // sequencer with its datapath and the registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      op_q       <= OP_GAIN;
      pc_q       <= '0;
      done_q     <= 1'b0;
      cnt_q      <= '0;
      div_cnt_q  <= '0;
      up_q       <= 1'b0;
      upper_q    <= 1'b0;
      m_q        <= '0;
      mul_a_q    <= '0;
      mul_b_q    <= '0;
      acc_q      <= '0;
      gain_q     <= '0;
      loss_q     <= '0;
      delta_q    <= '0;
      rem_q      <= '0;
      den_q      <= '0;
      quo_q      <= '0;
      mass_out_q <= '0;
      risk_out_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        // take a request, start with the constant gain kads*C
        S_IDLE: begin
          if (start_i) begin
            cnt_q   <= step_count_i;
            m_q     <= '0;
            mul_a_q <= ka_q;
            mul_b_q <= conc_q;
            op_q    <= OP_GAIN;
            pc_q    <= '0;
            state_q <= S_MUL;
          end
        end
        // accumulate one partial product per cycle
        S_MUL: begin
          acc_q <= (pc_q == '0) ? pp_sh : acc_q + pp_sh;
          if (pc_q == PC_LAST) begin
            state_q <= S_MEND;
          end else begin
            pc_q <= pc_q + 2'd1;
          end
        end
        // dispatch the scaled product
        S_MEND: begin
          pc_q <= '0;
          unique case (op_q)
            OP_GAIN: begin
              gain_q <= mul_sat_dn;
              if (cnt_q == '0) begin
                state_q <= S_RISK;
              end else begin
                mul_a_q <= kd_q;
                mul_b_q <= m_q;
                op_q    <= OP_LOSS;
                state_q <= S_MUL;
              end
            end
            OP_LOSS: begin
              loss_q  <= mul_sat_dn;
              state_q <= S_DIFF;
            end
            default: begin
              delta_q <= up_q ? mul_sat_dn : mul_sat_up;
              state_q <= S_UPD;
            end
          endcase
        end
        // net drift, then scale by the time step
        S_DIFF: begin
          up_q    <= !gl_diff[W1];
          mul_a_q <= dt_q;
          mul_b_q <= gl_diff[W1] ? lg_diff[W1-1:0] : gl_diff[W1-1:0];
          op_q    <= OP_DELTA;
          state_q <= S_MUL;
        end
        // advance the mass and loop
        S_UPD: begin
          m_q <= m_next;
          if (cnt_q == STEP_COUNT_BITS'(1)) begin
            state_q <= S_RISK;
          end else begin
            cnt_q   <= cnt_q - STEP_COUNT_BITS'(1);
            mul_a_q <= kd_q;
            mul_b_q <= m_next;
            op_q    <= OP_LOSS;
            state_q <= S_MUL;
          end
        end
        // pick the risk band
        S_RISK: begin
          mass_out_q <= m_q;
          div_cnt_q  <= '0;
          quo_q      <= '0;
          if (m_q <= safe_q) begin
            risk_out_q <= '0;
            done_q     <= 1'b1;
            state_q    <= S_IDLE;
          end else if (m_q >= hard_q) begin
            risk_out_q <= sei_pkg::RISK_ONE;
            done_q     <= 1'b1;
            state_q    <= S_IDLE;
          end else if (m_q <= gold_q) begin
            rem_q   <= m_q - safe_q;
            den_q   <= gold_q - safe_q;
            upper_q <= 1'b0;
            state_q <= S_DIV;
          end else begin
            rem_q   <= m_q - gold_q;
            den_q   <= hard_q - gold_q;
            upper_q <= 1'b1;
            state_q <= S_DIV;
          end
        end
        // one quotient bit per cycle, then finish the ramp
        S_DIV: begin
          rem_q     <= trial_ge ? trial_sub[W1-1:0] : trial[W1-1:0];
          quo_q     <= quo_next;
          div_cnt_q <= div_cnt_q + DCW'(1);
          if (div_cnt_q == DIV_LAST) begin
            risk_out_q <= RB'(quo_next) + (upper_q ? sei_pkg::RISK_HALF : '0);
            done_q     <= 1'b1;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign final_mass_o = mass_out_q;
  assign risk_level_o = risk_out_q;

  // a taken request keeps the block busy until its result is shown
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("request taken but block not busy");

  // the result appears only once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o && $past(busy_o))
    else $error("result strobe outside the end of a request");

  // the reported mass never exceeds the capacity
  a_mass_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> final_mass_o <= cap_q)
    else $error("final mass above capacity");

  // the running mass stays clamped during integration
  a_run_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> m_q <= cap_q)
    else $error("running mass above capacity");

  // the risk level never exceeds one
  a_risk_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> risk_level_o <= sei_pkg::RISK_ONE)
    else $error("risk level above one");

endmodule

// ===== verif/sorption_euler_integrator_core_test.sv =====
// Self-checking testbench for the sorption Euler integrator core.
module sorption_euler_integrator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_REGS    = 1 << sei_pkg::CFG_INDEX_BITS;
  localparam int unsigned CYCLE_LIMIT = 20_000_000;
  localparam int unsigned TAIL_CYCLES = 64;
  localparam int unsigned PHASES      = 5;
  localparam int unsigned PHASE_ITEMS = 16;
  localparam logic [63:0] MASS_MAX    = (64'd1 << (sei_pkg::WORD_BITS - 1)) - 64'd1;

  typedef logic [sei_pkg::WORD_BITS-1:0] word_t;
  typedef word_t setting_t [NUM_REGS];

  typedef struct {
    logic [sei_pkg::WORD_BITS-2:0] mass;
    logic [sei_pkg::RISK_BITS-1:0] risk;
  } mass_risk_t;

  typedef enum int {
    SET_REALISTIC,
    SET_RAW,
    SET_NEGATIVE_RATES,
    SET_UNORDERED
  } flavour_e;

  // Tracks register contents, predicts each request and checks the results
  class sorption_checker;
    word_t      regs [NUM_REGS];
    mass_risk_t awaited_mass_risk [$];
    int         mismatches;
    int         requests;
    int         results;
    int         writes;

    function new();
      foreach (regs[r]) regs[r] = '0;
      mismatches = 0;
      requests   = 0;
      results    = 0;
      writes     = 0;
    endfunction

    function int pending();
      return awaited_mass_risk.size();
    endfunction

    function void note_config(int index, word_t data);
      regs[index] = data;
      writes++;
    endfunction

    // Clamp a signed rate register at zero
    function logic [63:0] rate_of(int index);
      if (regs[index][sei_pkg::WORD_BITS-1])
        return '0;
      return 64'(regs[index]);
    endfunction

    function logic [63:0] magnitude_of(int index);
      return 64'(regs[index][sei_pkg::WORD_BITS-2:0]);
    endfunction

    // Exact product, shifted down by the fraction bits, optionally rounded up, saturated to the word
    function logic [63:0] fixed_product(logic [63:0] a, logic [63:0] b, bit round_up);
      logic [127:0] prod;
      logic [63:0]  r;
      prod = a * b;
      if ((prod >> (sei_pkg::FRAC_BITS + 64)) != 0)
        return MASS_MAX;
      r = prod[sei_pkg::FRAC_BITS +: 64];
      if (round_up && prod[sei_pkg::FRAC_BITS-1:0] != 0)
        r = r + 64'd1;
      return (r > MASS_MAX) ? MASS_MAX : r;
    endfunction

    // Run the Euler steps from zero mass
    function logic [63:0] integrate_mass(logic [sei_pkg::STEP_COUNT_BITS-1:0] steps);
      logic [63:0] gain, loss, dt, cap, kd, m, delta, next;
      kd   = rate_of(sei_pkg::REG_DESORPTION_RATE);
      dt   = magnitude_of(sei_pkg::REG_TIME_STEP);
      cap  = magnitude_of(sei_pkg::REG_MASS_CAPACITY);
      gain = fixed_product(rate_of(sei_pkg::REG_ADSORPTION_RATE),
                           magnitude_of(sei_pkg::REG_WATER_CONCENTRATION), 1'b0);
      m = '0;
      for (int i = 0; i < steps; i++) begin
        loss = fixed_product(kd, m, 1'b0);
        if (gain >= loss) begin
          next = m + fixed_product(dt, gain - loss, 1'b0);
        end else begin
          delta = fixed_product(dt, loss - gain, 1'b1);
          next  = (delta > m) ? 64'd0 : m - delta;
        end
        m = (next > cap) ? cap : next;
      end
      return m;
    endfunction

    // Score the mass against the bands, tests in fixed order
    function logic [sei_pkg::RISK_BITS-1:0] score_risk(logic [63:0] m);
      logic [63:0] safe_b, gold_b, hard_b, ramp;
      safe_b = magnitude_of(sei_pkg::REG_SAFE_BOUND);
      gold_b = magnitude_of(sei_pkg::REG_GOLD_BOUND);
      hard_b = magnitude_of(sei_pkg::REG_HARD_BOUND);
      if (m <= safe_b)
        return '0;
      if (m >= hard_b)
        return sei_pkg::RISK_ONE;
      if (m <= gold_b)
        ramp = (64'(sei_pkg::RISK_HALF) * (m - safe_b)) / (gold_b - safe_b);
      else
        ramp = 64'(sei_pkg::RISK_HALF)
             + (64'(sei_pkg::RISK_HALF) * (m - gold_b)) / (hard_b - gold_b);
      return ramp[sei_pkg::RISK_BITS-1:0];
    endfunction

    function void note_request(logic [sei_pkg::STEP_COUNT_BITS-1:0] steps);
      mass_risk_t  e;
      logic [63:0] m;
      m      = integrate_mass(steps);
      e.mass = m[sei_pkg::WORD_BITS-2:0];
      e.risk = score_risk(m);
      awaited_mass_risk.push_back(e);
      requests++;
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    task check_result(logic [sei_pkg::WORD_BITS-2:0] mass,
                      logic [sei_pkg::RISK_BITS-1:0] risk);
      mass_risk_t e;
      results++;
      if (awaited_mass_risk.size() == 0) begin
        report_mismatch($sformatf("unrequested result mass %h risk %h", mass, risk));
        return;
      end
      e = awaited_mass_risk.pop_front();
      if (mass !== e.mass)
        report_mismatch($sformatf("result %0d final_mass %h, predicted %h",
                                  results, mass, e.mass));
      if (risk !== e.risk)
        report_mismatch($sformatf("result %0d risk_level %h, predicted %h",
                                  results, risk, e.risk));
    endtask
  endclass

  logic                                clk_i;
  logic                                rst_ni       = 1'b0;
  logic                                cfg_valid_i  = 1'b0;
  logic                                cfg_ready_o;
  logic [sei_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i  = '0;
  logic [sei_pkg::WORD_BITS-1:0]       cfg_data_i   = '0;
  logic                                start_i      = 1'b0;
  logic                                busy_o;
  logic [sei_pkg::STEP_COUNT_BITS-1:0] step_count_i = '0;
  logic                                done_o;
  logic [sei_pkg::WORD_BITS-2:0]       final_mass_o;
  logic [sei_pkg::RISK_BITS-1:0]       risk_level_o;

  int unsigned     cycles = 0;
  int              settings_loaded = 0;
  sorption_checker tracker = new();

  sorption_euler_integrator_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .step_count_i (step_count_i),
    .done_o       (done_o),
    .final_mass_o (final_mass_o),
    .risk_level_o (risk_level_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Take each result in the cycle it is shown
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      tracker.check_result(final_mass_o, risk_level_o);
  end

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Hold a request until the block takes it, then idle at random
  task automatic issue_request(input logic [sei_pkg::STEP_COUNT_BITS-1:0] steps,
                               input int idle_pct);
    start_i      <= 1'b1;
    step_count_i <= steps;
    do @(posedge clk_i); while (busy_o);
    tracker.note_request(steps);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      do begin
        step_count_i <= sei_pkg::STEP_COUNT_BITS'($urandom);
        @(posedge clk_i);
      end while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Drain the block, then write every register
  task automatic load_setting(input setting_t setting);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0 || busy_o) @(posedge clk_i);
    for (int r = sei_pkg::REG_ADSORPTION_RATE; r <= sei_pkg::REG_HARD_BOUND; r++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= r[sei_pkg::CFG_INDEX_BITS-1:0];
      cfg_data_i  <= setting[r];
      do @(posedge clk_i); while (!cfg_ready_o);
      tracker.note_config(r, setting[r]);
    end
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= $urandom;
    settings_loaded++;
  endtask

  function automatic setting_t random_setting(flavour_e flavour);
    setting_t s;
    word_t    cap, lo, mid, hi, t;
    foreach (s[r]) s[r] = $urandom;
    if (flavour == SET_RAW)
      return s;
    cap = $urandom_range(2000 << 16, 1 << 16);
    s[sei_pkg::REG_ADSORPTION_RATE]     = $urandom_range(10 << 16, 0);
    s[sei_pkg::REG_DESORPTION_RATE]     = $urandom_range(2 << 16, 0);
    s[sei_pkg::REG_MASS_CAPACITY]       = cap;
    s[sei_pkg::REG_TIME_STEP]           = $urandom_range(1 << 16, 1 << 10);
    s[sei_pkg::REG_WATER_CONCENTRATION] = $urandom_range(100 << 16, 0);
    if (flavour == SET_NEGATIVE_RATES) begin
      if ($urandom_range(1))
        s[sei_pkg::REG_ADSORPTION_RATE] = $urandom | 32'h8000_0000;
      else
        s[sei_pkg::REG_DESORPTION_RATE] = $urandom | 32'h8000_0000;
    end
    lo  = $urandom_range(cap + cap / 8, 0);
    mid = $urandom_range(cap + cap / 8, 0);
    hi  = $urandom_range(cap + cap / 8, 0);
    // Sort the bands unless they are meant to be out of order
    if (flavour != SET_UNORDERED) begin
      if (lo > mid) begin t = lo; lo = mid; mid = t; end
      if (mid > hi) begin t = mid; mid = hi; hi = t; end
      if (lo > mid) begin t = lo; lo = mid; mid = t; end
    end
    s[sei_pkg::REG_SAFE_BOUND] = lo;
    s[sei_pkg::REG_GOLD_BOUND] = mid;
    s[sei_pkg::REG_HARD_BOUND] = hi;
    return s;
  endfunction

  // Mostly short integrations, a few long ones
  function automatic logic [sei_pkg::STEP_COUNT_BITS-1:0] random_step_count();
    int pick;
    pick = $urandom_range(99);
    if (pick < 85)
      return sei_pkg::STEP_COUNT_BITS'($urandom_range(127, 0));
    if (pick < 97)
      return sei_pkg::STEP_COUNT_BITS'($urandom_range(2047, 128));
    return sei_pkg::STEP_COUNT_BITS'($urandom_range(8191, 2048));
  endfunction

  initial begin : stimulus
    int idle_pct [PHASES];
    idle_pct = '{0, 80, 0, 29, 80};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers still at reset: capacity zero keeps the mass at zero
    issue_request(16'd0, 0);
    issue_request(16'd3, 0);

    // Ordered bands, capacity below equilibrium; zero steps and the longest run
    load_setting('{32'h0000_8000, 32'h0000_4000, 32'h000F_0000, 32'h0000_8000,
                   32'h000A_0000, 32'h0002_0000, 32'h0008_0000, 32'h000E_0000});
    issue_request(16'd0, 0);
    issue_request(16'd1, 0);
    issue_request(16'd2, 0);
    issue_request(16'd10, 0);
    issue_request(16'd100, 0);
    issue_request(16'd1000, 0);
    issue_request(16'hFFFF, 0);

    // Rates, capacity, time step and concentration at their largest values: products saturate
    load_setting('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'h0000_0000, 32'h4000_0000, 32'hFFFF_FFFF});
    issue_request(16'd1, 0);
    issue_request(16'd2, 0);
    issue_request(16'd3, 0);

    // Negative desorption counts as zero: linear rise up to the capacity clamp
    load_setting('{32'h0003_0000, 32'h8000_0000, 32'h0028_0000, 32'h0001_0000,
                   32'h0002_0000, 32'h0000_0000, 32'h0014_0000, 32'h001E_0000});
    issue_request(16'd5, 0);
    issue_request(16'd25, 0);
    issue_request(16'd0, 0);

    // Gold band below safe band
    load_setting('{32'h0001_0000, 32'h0000_199A, 32'h003C_0000, 32'h0000_4000,
                   32'h0005_0000, 32'h0014_0000, 32'h0005_0000, 32'h0028_0000});
    issue_request(16'd10, 0);
    issue_request(16'd40, 0);
    issue_request(16'd200, 0);
    issue_request(16'd2, 0);

    // Large desorption overshoots below zero; fractional step rounds up
    load_setting('{32'h0001_0000, 32'h0006_0000, 32'h0064_0000, 32'h0001_8001,
                   32'h0001_0000, 32'h8000_0000, 32'hFFFF_0000, 32'h0003_0000});
    issue_request(16'd1, 0);
    issue_request(16'd2, 0);
    issue_request(16'd3, 0);

    // Random phases, each under a fresh register setting and its own idling
    for (int ph = 0; ph < PHASES; ph++) begin
      load_setting(random_setting(flavour_e'(ph % 4)));
      for (int k = 0; k < PHASE_ITEMS; k++)
        issue_request(random_step_count(), idle_pct[ph]);
    end

    // Drain, then watch for stray results
    start_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.pending() != 0)
      tracker.report_mismatch($sformatf("%0d results never arrived", tracker.pending()));

    $display("ran %0d integrations under %0d register settings (%0d writes)",
             tracker.requests, settings_loaded, tracker.writes);
    $display("checked %0d results in %0d cycles, %0d mismatches",
             tracker.results, cycles, tracker.mismatches);
    if (tracker.mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
